// ===== hdl/mchw_pkg.sv =====
// ----------------------------------------------------------------------------
// mchw_pkg: shared definitions for the heartbeat watchdog
// Channel count, field widths, opcodes, register indexes and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mchw_pkg;

  // Number of monitored channels and the width of a channel index.
  localparam int CHANNELS = 32;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths.
  localparam int DATA_W      = 32;
  localparam int OPCODE_W    = 3;
  localparam int CFG_ADDR_W  = 2;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 64;

  // Operation codes carried by an input item.
  localparam logic [OPCODE_W-1:0] OP_TICK        = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_HEARTBEAT   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_CHECK       = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_SET_TIMEOUT = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR       = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HANDLER  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PRIORITY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;      // an item is accepted this cycle
    logic            walk;      // visit the channel entry at idx
    logic [CH_W-1:0] idx;       // channel entry being visited
    logic            out_load;  // move the finished result to the output
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // the output register can take a result this cycle
  } status_t;

endpackage

// ===== hdl/multi_channel_heartbeat_watchdog_core.sv =====
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog_core: per-channel liveness monitor
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
// Every input item yields exactly one result item. Tick, clear-flags and
// unused opcodes go from accept straight to the finish state. Heartbeat,
// check and set-timeout items visit the channel table one entry per cycle
// and then pass a flush state before the finish state. The result goes to
// an output register, so a new item can be accepted while the previous
// result still waits. The tables need no clearing after reset.
module multi_channel_heartbeat_watchdog_core
  import mchw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Fields from bit 0: opcode[2:0], channel_mask[34:3], timeout_value[66:35].
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // Fields from bit 0: offline_flags[31:0], notify_mask[63:32].
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [DATA_W-1:0]      cfg_wdata
);

  cmd_t                cmd;
  status_t             sts;
  logic [OPCODE_W-1:0] in_opcode;
  logic [DATA_W-1:0]   in_channel_mask;
  logic [DATA_W-1:0]   in_timeout_value;
  logic [DATA_W-1:0]   out_offline_flags;
  logic [DATA_W-1:0]   out_notify_mask;

  // Unpack the input item.
  assign in_opcode        = in_tdata[2:0];
  assign in_channel_mask  = in_tdata[34:3];
  assign in_timeout_value = in_tdata[66:35];

  // Pack the result item.
  assign out_tdata = {out_notify_mask, out_offline_flags};

  mchw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd)
  );

  mchw_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_opcode         (in_opcode),
    .in_channel_mask   (in_channel_mask),
    .in_timeout_value  (in_timeout_value),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_offline_flags (out_offline_flags),
    .out_notify_mask   (out_notify_mask)
  );

endmodule

// ===== hdl/mchw_ctrl.sv =====
// ----------------------------------------------------------------------------
// mchw_ctrl: sequencing controller
// Accepts one item at a time, walks the channel table for heartbeat, check
// and set-timeout items, then hands the result to the output register.
// ----------------------------------------------------------------------------
module mchw_ctrl
  import mchw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  status_t             sts,
  output cmd_t                cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_FLUSH  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CH_W-1:0] idx_r, idx_nxt;
  logic            accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          if (in_opcode inside {OP_HEARTBEAT, OP_CHECK, OP_SET_TIMEOUT}) begin
            state_nxt = ST_WALK;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_WALK: begin
        idx_nxt = idx_r + CH_W'(1);
        if (idx_r == CH_W'(CHANNELS - 1)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // The compare stage still holds the last channel.
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd.load     = accept;
    cmd.walk     = (state_r == ST_WALK);
    cmd.idx      = idx_r;
    cmd.out_load = (state_r == ST_FINISH) && sts.out_free;
  end

endmodule

// ===== hdl/mchw_dp.sv =====
// ----------------------------------------------------------------------------
// mchw_dp: watchdog datapath
// Holds the configuration, the millisecond counter, the per-channel
// last-seen and timeout tables, the offline flags and the output register.
// ----------------------------------------------------------------------------
module mchw_dp
  import mchw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               sts,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic [DATA_W-1:0]     in_channel_mask,
  input  logic [DATA_W-1:0]     in_timeout_value,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DATA_W-1:0]     cfg_wdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_offline_flags,
  output logic [DATA_W-1:0]     out_notify_mask
);

  // Configuration registers.
  logic [CHANNELS-1:0] enable_r;
  logic [CHANNELS-1:0] handler_r;
  logic                prio_r;

  // Item registers.
  logic [OPCODE_W-1:0] op_r;
  logic [CHANNELS-1:0] mask_r;
  logic [DATA_W-1:0]   tmo_r;

  // Monitor state.
  logic [DATA_W-1:0]   now_r;
  logic [CHANNELS-1:0] offline_r, offline_nxt;
  logic [CHANNELS-1:0] notify_r, notify_nxt;
  logic                fired_r, fired_nxt;

  // Channel tables with per-entry valid bits; an unwritten entry reads as zero.
  logic [DATA_W-1:0]   ls_mem [CHANNELS];
  logic [DATA_W-1:0]   to_mem [CHANNELS];
  logic [CHANNELS-1:0] ls_vld_r;
  logic [CHANNELS-1:0] to_vld_r;
  logic [DATA_W-1:0]   ls_q_r, to_q_r;
  logic                ls_vq_r, to_vq_r;

  // Compare stage.
  logic                chk_v_r;
  logic [CH_W-1:0]     chk_idx_r;

  // Output register.
  logic                out_valid_r;
  logic [CHANNELS-1:0] out_flags_r;
  logic [CHANNELS-1:0] out_notify_r;

  logic [CHANNELS-1:0] mask_in;
  logic [CHANNELS-1:0] act;
  logic                is_hb, is_chk, is_set;
  logic                ls_we, to_we;
  logic [DATA_W-1:0]   ls_val, to_val, elapsed;
  logic                late;

  assign mask_in = in_channel_mask[CHANNELS-1:0];
  assign act     = mask_r & enable_r;
  assign is_hb   = (op_r == OP_HEARTBEAT);
  assign is_chk  = (op_r == OP_CHECK);
  assign is_set  = (op_r == OP_SET_TIMEOUT);
  assign ls_we   = cmd.walk && is_hb && act[cmd.idx];
  assign to_we   = cmd.walk && is_set && mask_r[cmd.idx];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= '0;
      handler_r <= '0;
      prio_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ENABLE:   enable_r  <= cfg_wdata[CHANNELS-1:0];
        REG_HANDLER:  handler_r <= cfg_wdata[CHANNELS-1:0];
        REG_PRIORITY: prio_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Capture the accepted item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      mask_r <= mask_in;
      tmo_r  <= in_timeout_value;
    end
  end

  // Millisecond counter, wrapping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
    end else if (cmd.load && (in_opcode == OP_TICK)) begin
      now_r <= now_r + DATA_W'(1);
    end
  end

  // Last-seen table.
  always_ff @(posedge clk) begin
    if (ls_we) begin
      ls_mem[cmd.idx] <= now_r;
    end
    ls_q_r  <= ls_mem[cmd.idx];
    ls_vq_r <= ls_vld_r[cmd.idx];
  end

  // Timeout table.
  always_ff @(posedge clk) begin
    if (to_we) begin
      to_mem[cmd.idx] <= tmo_r;
    end
    to_q_r  <= to_mem[cmd.idx];
    to_vq_r <= to_vld_r[cmd.idx];
  end

  // Valid bits of both tables.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ls_vld_r <= '0;
      to_vld_r <= '0;
    end else begin
      if (ls_we) begin
        ls_vld_r[cmd.idx] <= 1'b1;
      end
      if (to_we) begin
        to_vld_r[cmd.idx] <= 1'b1;
      end
    end
  end

  // The compare-stage valid and index are registered alongside the table read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_v_r <= 1'b0;
    end else begin
      chk_v_r <= cmd.walk && is_chk && act[cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= cmd.idx;
  end

  assign ls_val  = ls_vq_r ? ls_q_r : '0;
  assign to_val  = to_vq_r ? to_q_r : '0;
  assign elapsed = now_r - ls_val;
  assign late    = (elapsed > to_val);

  // Offline flags and notify accumulation.
  always_comb begin
    offline_nxt = offline_r;
    notify_nxt  = notify_r;
    fired_nxt   = fired_r;
    if (cmd.load) begin
      notify_nxt = '0;
      fired_nxt  = 1'b0;
      if (in_opcode == OP_CLEAR) begin
        offline_nxt = offline_r & ~mask_in;
      end
    end else if (chk_v_r) begin
      if (late) begin
        offline_nxt[chk_idx_r] = 1'b1;
        // In priority mode only the first handled channel is notified.
        if (handler_r[chk_idx_r] && !fired_r) begin
          notify_nxt[chk_idx_r] = 1'b1;
          if (prio_r) begin
            fired_nxt = 1'b1;
          end
        end
      end else begin
        offline_nxt[chk_idx_r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offline_r <= '0;
      notify_r  <= '0;
      fired_r   <= 1'b0;
    end else begin
      offline_r <= offline_nxt;
      notify_r  <= notify_nxt;
      fired_r   <= fired_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_flags_r  <= offline_r;
      out_notify_r <= notify_r;
    end
  end

  assign sts.out_free      = !out_valid_r || out_tready;
  assign out_tvalid        = out_valid_r;
  assign out_offline_flags = DATA_W'(out_flags_r);
  assign out_notify_mask   = DATA_W'(out_notify_r);

endmodule

// ===== hdl/mchw_checker.sv =====
// ----------------------------------------------------------------------------
// mchw_checker: port-level checks for the heartbeat watchdog
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module mchw_checker
  import mchw_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready
);

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // Only channels that are offline are ever notified.
  a_notify_offline: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[63:32] & ~out_tdata[31:0]) == 32'd0))
    else $error("notified channel is not offline");

  // The block works on one item at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in progress");

endmodule

bind multi_channel_heartbeat_watchdog_core mchw_checker u_mchw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
